FILE: src/aoc_pkg.sv
// shared types, constants and helpers of the alpha over compositor
// no dependencies; imported by aoc_mix and alpha_over_compositor
package aoc_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int PIX_W  = 32;
  localparam int CFG_W  = 10;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W  = 9;
  // signed target coordinate: position, plus the offset for blend items
  localparam int TGT_W  = POS_W + 3;
  // signed compare width, holds the clamped size too
  localparam int CMP_W  = (TGT_W > $clog2(MAX_WIDTH + 1) + 1) ?
                          ((TGT_W > $clog2(MAX_HEIGHT + 1) + 1) ? TGT_W + 1 :
                           $clog2(MAX_HEIGHT + 1) + 2) :
                          ((TGT_W > $clog2(MAX_HEIGHT + 1) + 1) ?
                           $clog2(MAX_WIDTH + 1) + 2 :
                           (($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                            $clog2(MAX_WIDTH + 1) + 2 : $clog2(MAX_HEIGHT + 1) + 2));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACK_WIDTH  = 2'd0,
    CFG_BACK_HEIGHT = 2'd1,
    CFG_OFFSET_X    = 2'd2,
    CFG_OFFSET_Y    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_BLEND = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MIX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } out_item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  // exact x / 255 for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

FILE: src/aoc_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module aoc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/aoc_mix.sv
// blend datapath: registered products, then the divide by 255
// depends on aoc_pkg
module aoc_mix import aoc_pkg::*; (
  input  logic   clk_i,
  input  logic   load_i,
  input  pixel_t back_i,
  input  pixel_t fore_i,
  output pixel_t mix_o
);

  logic [15:0] sum_r_q, sum_g_q, sum_b_q, sum_a_q;
  logic [15:0] sum_r_d, sum_g_d, sum_b_d, sum_a_d;
  logic [7:0]  back_a_q;
  logic [7:0]  inv_af, inv_ab;

  always_comb begin
    inv_af  = 8'd255 - fore_i.a;
    inv_ab  = 8'd255 - back_i.a;
    sum_r_d = ({8'd0, inv_af} * {8'd0, back_i.r}) + ({8'd0, fore_i.a} * {8'd0, fore_i.r});
    sum_g_d = ({8'd0, inv_af} * {8'd0, back_i.g}) + ({8'd0, fore_i.a} * {8'd0, fore_i.g});
    sum_b_d = ({8'd0, inv_af} * {8'd0, back_i.b}) + ({8'd0, fore_i.a} * {8'd0, fore_i.b});
    sum_a_d = {8'd0, inv_ab} * {8'd0, fore_i.a};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_r_q  <= sum_r_d;
      sum_g_q  <= sum_g_d;
      sum_b_q  <= sum_b_d;
      sum_a_q  <= sum_a_d;
      back_a_q <= back_i.a;
    end
  end

  always_comb begin
    mix_o.r = div255(sum_r_q);
    mix_o.g = div255(sum_g_q);
    mix_o.b = div255(sum_b_q);
    // cannot exceed 255
    mix_o.a = back_a_q + div255(sum_a_q);
  end

endmodule

FILE: src/alpha_over_compositor.sv
// alpha over compositor: background frame store with write, blend and read
// an accepted item goes through the read, mix and done states before its result is registered
// items are handled one at a time, through the store read, mix and write-back sequence
// the input stalls from acceptance until the result is loaded into the output register
// reset idles control, sets size 512 x 512, zero offsets; store is undefined until written
// depends on aoc_pkg, aoc_ram, aoc_mix
module alpha_over_compositor import aoc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  state_e state_q, state_d;

  logic [CFG_W-1:0] back_width_q, back_height_q, offset_x_q, offset_y_q;

  in_item_t          item_q;
  logic              ok_q, ok_d;
  logic [ADDR_W-1:0] addr_q, addr_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  logic   in_accept, ram_re, ram_we, mix_load;
  pixel_t ram_rdata, mix_pix, fore_pix, res_pix;

  // target location and inside test
  logic signed [TGT_W-1:0] tgt_x, tgt_y;
  logic signed [CMP_W-1:0] w_eff, h_eff;
  logic [ADDR_W-1:0] x_u, y_u;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  always_comb begin
    w_eff = (int'(back_width_q) > MAX_WIDTH) ? CMP_W'(MAX_WIDTH) :
            CMP_W'({1'b0, back_width_q});
    h_eff = (int'(back_height_q) > MAX_HEIGHT) ? CMP_W'(MAX_HEIGHT) :
            CMP_W'({1'b0, back_height_q});
    if (in_item_i.command == CMD_BLEND) begin
      tgt_x = TGT_W'(signed'({1'b0, in_item_i.pos_x})) + TGT_W'(signed'(offset_x_q));
      tgt_y = TGT_W'(signed'({1'b0, in_item_i.pos_y})) + TGT_W'(signed'(offset_y_q));
    end else begin
      tgt_x = TGT_W'(signed'({1'b0, in_item_i.pos_x}));
      tgt_y = TGT_W'(signed'({1'b0, in_item_i.pos_y}));
    end
    ok_d = (tgt_x >= 0) && (tgt_y >= 0) &&
           (CMP_W'(tgt_x) < w_eff) && (CMP_W'(tgt_y) < h_eff) &&
           (in_item_i.command == CMD_WRITE || in_item_i.command == CMD_BLEND ||
            in_item_i.command == CMD_READ);
    x_u    = ADDR_W'(unsigned'(tgt_x));
    y_u    = ADDR_W'(unsigned'(tgt_y));
    addr_d = ADDR_W'(y_u * MAX_WIDTH + x_u);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_width_q  <= CFG_W'(512);
      back_height_q <= CFG_W'(512);
      offset_x_q    <= '0;
      offset_y_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BACK_WIDTH:  back_width_q  <= cfg_data_i;
        CFG_BACK_HEIGHT: back_height_q <= cfg_data_i;
        CFG_OFFSET_X:    offset_x_q    <= cfg_data_i;
        CFG_OFFSET_Y:    offset_y_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item_i;
      ok_q   <= ok_d;
      addr_q <= addr_d;
    end
    out_item_q <= out_item_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign fore_pix = '{r: item_q.red, g: item_q.green, b: item_q.blue, a: item_q.alpha};

  always_comb begin
    case (item_q.command)
      CMD_WRITE: res_pix = fore_pix;
      CMD_BLEND: res_pix = mix_pix;
      default:   res_pix = ram_rdata;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    mix_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_MIX;
      end
      ST_MIX: begin
        mix_load = 1'b1;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        // wait for room in the output register
        if (!out_valid_q || !out_stall_i) begin
          ram_we      = ok_q && (item_q.command == CMD_WRITE ||
                                 item_q.command == CMD_BLEND);
          out_valid_d = 1'b1;
          if (ok_q) begin
            out_item_d = '{status: 1'b0, out_red: res_pix.r, out_green: res_pix.g,
                           out_blue: res_pix.b, out_alpha: res_pix.a};
          end else begin
            out_item_d = '{status: 1'b1, default: '0};
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  aoc_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (res_pix),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  aoc_mix u_mix (
    .clk_i  (clk_i),
    .load_i (mix_load),
    .back_i (ram_rdata),
    .fore_i (fore_pix),
    .mix_o  (mix_pix)
  );

endmodule
